[rtl/cfl_pkg.sv]
// Shared types and constants for the cascaded fixed-point low-pass filter.
`default_nettype none
package cfl_pkg;

  localparam int WordW      = 32;
  localparam int FracBits   = 16;
  localparam int InputShift = 16;
  localparam int SampleW    = 16;
  localparam int GainW      = 17;
  localparam int CfgIdxW    = 1;
  localparam int StatusW    = 2;

  localparam logic [GainW-1:0] MaxGain    = GainW'(1 << FracBits);
  localparam logic [GainW-1:0] GainReset  = GainW'(6554);
  localparam logic [WordW-1:0] RoundAdd   = WordW'(1 << (FracBits - 1));

  typedef enum logic [StatusW-1:0] {
    STAT_FILTERED = 2'd0,
    STAT_PRIMED   = 2'd1,
    STAT_PASS     = 2'd2,
    STAT_RESTART  = 2'd3
  } cfl_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE = 1'b0,
    CFG_GAIN   = 1'b1
  } cfl_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } cfl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        start;     // latch the scaled sample, rewind to the first pole
    logic        prime;     // load every pole with the scaled sample
    logic        sub;       // register the pole difference
    logic        mul;       // register the rounded scaled product
    logic        acc;       // update the current pole and advance
    logic        restart;   // drop the primed flag after an overflow
    logic        set_code;  // record the result code
    cfl_status_e code;
    logic        load_out;  // move the result into the output register
  } cfl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enable;
    logic primed;
    logic sub_ovf;
    logic acc_ovf;
    logic last_pole;
  } cfl_stat_t;

endpackage
`default_nettype wire

[rtl/cfl_datapath.sv]
// Datapath: configuration registers, pole store, shared multiplier and output register.
`default_nettype none
module cfl_datapath #(
  parameter int NUM_POLES = 2
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [cfl_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  wire  [cfl_pkg::GainW-1:0]              cfg_data_i,
  input  wire  signed [cfl_pkg::SampleW-1:0]     sample_i,
  input  cfl_pkg::cfl_cmd_t                      cmd_i,
  output cfl_pkg::cfl_stat_t                     stat_o,
  output logic signed [cfl_pkg::WordW-1:0]       filtered_value_o,
  output logic [cfl_pkg::StatusW-1:0]            status_o
);
  import cfl_pkg::*;

  localparam int IdxW  = (NUM_POLES > 1) ? $clog2(NUM_POLES) : 1;
  localparam int ProdW = WordW + GainW + 1;
  localparam int SumW  = WordW + 1;

  logic                 enable_q;
  logic [GainW-1:0]     gain_q;
  logic                 primed_q;
  logic [WordW-1:0]     x_q;
  logic [WordW-1:0]     cur_q;
  logic [WordW-1:0]     diff_q;
  logic [SumW-1:0]      sum_q;
  logic [IdxW-1:0]      idx_q;
  cfl_status_e          code_q;
  logic [WordW-1:0]     pole_q [NUM_POLES];
  logic [WordW-1:0]     out_value_q;
  cfl_status_e          out_status_q;

  logic [WordW-1:0]        ext_w;
  logic [WordW-1:0]        x_w;
  logic [GainW-1:0]        k_w;
  logic [WordW-1:0]        pole_w;
  logic [WordW-1:0]        diff_w;
  logic signed [ProdW-1:0] prod_w;
  logic signed [ProdW-1:0] rnd_w;
  logic [WordW-1:0]        step_w;
  logic [WordW-1:0]        next_w;
  logic                    sub_ovf_w;
  logic                    add_ovf_w;

  assign ext_w  = {{(WordW - SampleW){sample_i[SampleW-1]}}, sample_i};
  assign x_w    = ext_w << InputShift;
  assign k_w    = (gain_q > MaxGain) ? MaxGain : gain_q;
  assign pole_w = pole_q[idx_q];

  assign diff_w    = cur_q - pole_w;
  assign sub_ovf_w = (cur_q[WordW-1] ^ pole_w[WordW-1]) & (cur_q[WordW-1] ^ diff_w[WordW-1]);

  // Full 50-bit product plus rounding; the rounded sum shifted down by FracBits is kept in 33 bits.
  assign prod_w = $signed(diff_q) * $signed({1'b0, k_w});
  assign rnd_w  = prod_w + $signed(ProdW'(RoundAdd));

  assign step_w    = sum_q[WordW-1:0];
  assign next_w    = step_w + pole_w;
  assign add_ovf_w = (sum_q[SumW-1] ^ sum_q[SumW-2])
                   | (~(step_w[WordW-1] ^ pole_w[WordW-1]) & (step_w[WordW-1] ^ next_w[WordW-1]));

  assign stat_o.enable    = enable_q;
  assign stat_o.primed    = primed_q;
  assign stat_o.sub_ovf   = sub_ovf_w;
  assign stat_o.acc_ovf   = add_ovf_w;
  assign stat_o.last_pole = (idx_q == IdxW'(NUM_POLES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      gain_q   <= GainReset;
      primed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENABLE: enable_q <= cfg_data_i[0];
          CFG_GAIN:   gain_q   <= cfg_data_i;
          default:    ;
        endcase
        primed_q <= 1'b0;
      end else if (cmd_i.restart) begin
        primed_q <= 1'b0;
      end else if (cmd_i.prime) begin
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q   <= x_w;
      cur_q <= x_w;
      idx_q <= '0;
    end
    if (cmd_i.prime) begin
      for (int i = 0; i < NUM_POLES; i++) begin
        pole_q[i] <= x_w;
      end
    end
    if (cmd_i.sub) begin
      diff_q <= diff_w;
    end
    if (cmd_i.mul) begin
      sum_q <= rnd_w[FracBits +: SumW];
    end
    if (cmd_i.acc) begin
      pole_q[idx_q] <= next_w;
      cur_q         <= next_w;
      idx_q         <= idx_q + IdxW'(1);
    end
    if (cmd_i.set_code) begin
      code_q <= cmd_i.code;
    end
    if (cmd_i.load_out) begin
      out_value_q  <= (code_q == STAT_FILTERED) ? cur_q : x_q;
      out_status_q <= code_q;
    end
  end

  assign filtered_value_o = $signed(out_value_q);
  assign status_o         = out_status_q;

  a_acc_writes_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc |=> pole_q[$past(idx_q)] == cur_q)
    else $error("pole update and running value disagree");

  a_prime_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.prime && !cfg_we_i && !cmd_i.restart) |=> primed_q && (cur_q == pole_q[0]))
    else $error("priming did not load the first pole");

endmodule
`default_nettype wire

[rtl/cfl_ctrl.sv]
// Controller: sequences subtract, multiply and accumulate over the poles.
`default_nettype none
module cfl_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  cfl_pkg::cfl_stat_t  stat_i,
  output cfl_pkg::cfl_cmd_t   cmd_o
);
  import cfl_pkg::*;

  cfl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free_w;

  assign out_free_w = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (stat_i.enable && stat_i.primed) ? ST_SUB : ST_DONE;
        end
      end
      ST_SUB:  state_d = stat_i.sub_ovf ? ST_DONE : ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = (stat_i.acc_ovf || stat_i.last_pole) ? ST_DONE : ST_SUB;
      ST_DONE: state_d = out_free_w ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.code = STAT_FILTERED;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (!stat_i.enable) begin
            cmd_o.set_code = 1'b1;
            cmd_o.code     = STAT_PASS;
          end else if (!stat_i.primed) begin
            cmd_o.prime    = 1'b1;
            cmd_o.set_code = 1'b1;
            cmd_o.code     = STAT_PRIMED;
          end
        end
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        if (stat_i.sub_ovf) begin
          cmd_o.restart  = 1'b1;
          cmd_o.set_code = 1'b1;
          cmd_o.code     = STAT_RESTART;
        end
      end
      ST_MUL: cmd_o.mul = 1'b1;
      ST_ACC: begin
        if (stat_i.acc_ovf) begin
          cmd_o.restart  = 1'b1;
          cmd_o.set_code = 1'b1;
          cmd_o.code     = STAT_RESTART;
        end else begin
          cmd_o.acc = 1'b1;
          if (stat_i.last_pole) begin
            cmd_o.set_code = 1'b1;
            cmd_o.code     = STAT_FILTERED;
          end
        end
      end
      ST_DONE: cmd_o.load_out = out_free_w;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> out_valid_q)
    else $error("finished transaction produced no result");

endmodule
`default_nettype wire

[rtl/cascaded_fixed_point_lowpass.sv]
// Top level of the cascaded fixed-point low-pass filter.
`default_nettype none
// Cascade of NUM_POLES first-order IIR low-pass stages in signed Q15.16. Each
// sample is sign-extended and shifted left into a 32-bit word x; with the
// filter enabled every stage does pole += K*(in - pole), with in = x for the
// first stage and each stage feeding its new value to the next as its in;
// the last stage's value is the result. K is the gain register in unsigned
// Q1.16, values above 1.0 act as 1.0. The first sample after reset, after any
// configuration write or after an arithmetic overflow loads every pole with x
// and is returned unchanged (status 1); an overflow returns x with status 3;
// with the filter disabled x comes back with status 2 and neither a pole nor
// the primed flag moves. A filtered sample steps through subtract, multiply
// and accumulate states for each pole, then a done state that loads the
// result register, after which the next sample can be taken; a passthrough
// or priming sample goes from acceptance straight to the done state. Each
// pole goes through subtract, multiply and accumulate on the one shared 32x18
// multiplier, and one sample is in flight at a time. A result waiting in the
// output register does not block acceptance of the next transaction; only a
// second finished result waits for it to drain, which holds the input stalled
// for as long as the receiver stalls. Write configuration only while no
// transaction is in flight.
module cascaded_fixed_point_lowpass #(
  parameter int NUM_POLES = 2
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write port
  input  wire                                 cfg_we_i,
  input  wire  [cfl_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire  [cfl_pkg::GainW-1:0]           cfg_data_i,
  // sample channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  signed [cfl_pkg::SampleW-1:0]  sample_i,
  // result channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [cfl_pkg::WordW-1:0]    filtered_value_o,
  output logic [cfl_pkg::StatusW-1:0]         status_o
);
  import cfl_pkg::*;

  cfl_cmd_t  cmd_w;
  cfl_stat_t stat_w;

  // Sequencer: owns the handshakes and steps through the poles.
  cfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat_w),
    .cmd_o       (cmd_w)
  );

  // Arithmetic, pole store and registers; acts on controller commands and configuration writes.
  cfl_datapath #(
    .NUM_POLES (NUM_POLES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .cmd_i            (cmd_w),
    .stat_o           (stat_w),
    .filtered_value_o (filtered_value_o),
    .status_o         (status_o)
  );

endmodule
`default_nettype wire
